[design/phf_pkg.sv]
package phf_pkg;

  // sizes
  localparam int PASS_BYTES  = 32;
  localparam int HOLD_DEPTH  = 5;
  localparam int HELD_CNT_W  = $clog2(HOLD_DEPTH + 1);
  localparam int NUM_PAT     = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int POS_W       = 5;
  localparam int PIDX_W      = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AUTH_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_WORD0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_WORD1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_WORD2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_WORD3  = 3'd5;

  // characters
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // header prefixes, lower case
  localparam int PAT_PROXY_KA = 0;
  localparam int PAT_AUTH     = 1;
  localparam int PAT_PROXY    = 2;
  localparam int PAT_HOST     = 3;
  localparam int PAT_CONN_KA  = 4;
  localparam int PAT_CLEN     = 5;

  localparam logic [8*28-1:0] TXT_PROXY_KA = "proxy-connection: keep-alive";
  localparam logic [8*27-1:0] TXT_AUTH     = "proxy-authorization: basic ";
  localparam logic [8*5-1:0]  TXT_PROXY    = "proxy";
  localparam logic [8*6-1:0]  TXT_HOST     = "host: ";
  localparam logic [8*22-1:0] TXT_CONN_KA  = "connection: keep-alive";
  localparam logic [8*16-1:0] TXT_CLEN     = "content-length: ";

  localparam logic [POS_W-1:0] POS_MAX  = 5'd31;
  localparam logic [POS_W-1:0] POS_HOST = 5'd6;

  typedef enum logic [1:0] {
    MODE_DECIDE  = 2'd0,
    MODE_FORWARD = 2'd1,
    MODE_DROP    = 2'd2,
    MODE_END     = 2'd3
  } line_mode_t;

  typedef struct packed {
    logic             auth_enable;
    logic [5:0]       pass_length;
    logic [3:0][63:0] pass_word;
  } cfg_t;

  // one forwarding job: held bytes first, then the current byte
  typedef struct packed {
    logic [HOLD_DEPTH-1:0][7:0] held;
    logic [HELD_CNT_W-1:0]      held_cnt;
    logic [7:0]                 cur_byte;
    logic                       host;
    logic                       done;
    logic                       keep_alive;
    logic                       authorized;
    logic [31:0]                content_length;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } q_stat_t;

  function automatic logic [POS_W-1:0] pat_len(input int i);
    logic [POS_W-1:0] l;
    unique case (i)
      PAT_PROXY_KA: l = 5'd28;
      PAT_AUTH:     l = 5'd27;
      PAT_PROXY:    l = 5'd5;
      PAT_HOST:     l = 5'd6;
      PAT_CONN_KA:  l = 5'd22;
      PAT_CLEN:     l = 5'd16;
      default:      l = 5'd0;
    endcase
    return l;
  endfunction

  // character of prefix i at line position pos, first character at the top
  function automatic logic [7:0] pat_char(input int i, input logic [POS_W-1:0] pos);
    int k;
    logic [7:0] c;
    k = int'(pat_len(i)) - 1 - int'(pos);
    c = 8'h00;
    if (k >= 0) begin
      unique case (i)
        PAT_PROXY_KA: c = TXT_PROXY_KA[8*k +: 8];
        PAT_AUTH:     c = TXT_AUTH[8*k +: 8];
        PAT_PROXY:    c = TXT_PROXY[8*k +: 8];
        PAT_HOST:     c = TXT_HOST[8*k +: 8];
        PAT_CONN_KA:  c = TXT_CONN_KA[8*k +: 8];
        PAT_CLEN:     c = TXT_CLEN[8*k +: 8];
        default:      c = 8'h00;
      endcase
    end
    return c;
  endfunction

endpackage

[design/phf_in_if.sv]
interface phf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       head_start;
  logic       host_known;

  modport source (output valid, output in_byte, output head_start, output host_known,
                  input ready);
  modport sink (input valid, input in_byte, input head_start, input host_known,
                output ready);
endinterface

[design/phf_out_if.sv]
interface phf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        host_byte_flag;
  logic        head_done;
  logic        keep_alive;
  logic        authorized;
  logic [31:0] content_length;

  modport source (output valid, output out_byte, output host_byte_flag, output head_done,
                  output keep_alive, output authorized, output content_length,
                  input ready);
  modport sink (input valid, input out_byte, input host_byte_flag, input head_done,
                input keep_alive, input authorized, input content_length,
                output ready);
endinterface

[design/phf_cfg_if.sv]
interface phf_cfg_if import phf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [63:0]          wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

[design/phf_front.sv]
module phf_front import phf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  phf_in_if.sink   in_chan,
  input  cfg_t     cfg,
  input  q_stat_t  q_stat,
  output logic     push,
  output cmd_t     push_cmd
);

  logic                  irl_r, irl_nxt, e_irl;
  logic [POS_W-1:0]      pos_r, pos_nxt, e_pos;
  line_mode_t            mode_r, mode_nxt, e_mode;
  logic [NUM_PAT-1:0]    alive_r, alive_nxt, e_alive;
  logic [PIDX_W-1:0]     pidx_r, pidx_nxt, e_pidx;
  logic                  pass_ok_r, pass_ok_nxt, e_pass_ok;
  logic [31:0]           len_r, len_nxt, e_len;
  logic                  digits_r, digits_nxt, e_digits;
  logic                  ka_r, ka_nxt, e_ka;
  logic                  auth_r, auth_nxt, e_auth;
  logic                  hmiss_r, hmiss_nxt, e_hmiss;
  logic                  htaken_r, htaken_nxt, e_htaken;
  logic [HOLD_DEPTH-1:0][7:0] held_r, held_nxt;

  logic                  accept;
  logic [7:0]            b;
  logic [7:0]            lb;
  logic                  is_digit;
  logic [35:0]           len_mul;
  logic [31:0]           len_sat;
  logic [NUM_PAT-1:0]    alive_upd;
  logic [NUM_PAT-1:0]    done_mask;
  logic [PIDX_W-1:0]     plen;
  logic [PIDX_W-1:0]     pidx_inc;
  logic [7:0]            pass_char;
  logic                  host;
  logic [HELD_CNT_W-1:0] flush_cnt;

  assign in_chan.ready = !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign b             = in_chan.in_byte;

  // state as seen by this item, after a head start clears it
  always_comb begin
    e_irl     = irl_r;
    e_pos     = pos_r;
    e_mode    = mode_r;
    e_alive   = alive_r;
    e_pidx    = pidx_r;
    e_pass_ok = pass_ok_r;
    e_len     = len_r;
    e_digits  = digits_r;
    e_ka      = ka_r;
    e_auth    = auth_r;
    e_hmiss   = hmiss_r;
    e_htaken  = htaken_r;
    if (in_chan.head_start) begin
      e_irl     = 1'b1;
      e_pos     = '0;
      e_mode    = MODE_DECIDE;
      e_alive   = '1;
      e_pidx    = '0;
      e_pass_ok = 1'b0;
      e_len     = '0;
      e_digits  = 1'b0;
      e_ka      = 1'b0;
      e_auth    = 1'b0;
      e_hmiss   = !in_chan.host_known;
      e_htaken  = 1'b0;
    end
  end

  // byte classification
  assign lb       = (b >= CHAR_UC_A && b <= CHAR_UC_Z) ? b + CASE_DELTA : b;
  assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign len_mul  = ({4'b0, e_len} << 3) + ({4'b0, e_len} << 1)
                    + {32'b0, 4'(b - CHAR_ZERO)};
  assign len_sat  = (len_mul[35:32] != 4'b0) ? '1 : len_mul[31:0];

  // password compare
  assign plen      = (cfg.pass_length > PIDX_W'(PASS_BYTES)) ? PIDX_W'(PASS_BYTES)
                                                             : cfg.pass_length;
  assign pidx_inc  = e_pidx + PIDX_W'(1);
  assign pass_char = cfg.pass_word[e_pidx[4:3]][8*e_pidx[2:0] +: 8];

  // prefix matchers, one per header pattern
  always_comb begin
    alive_upd = e_alive;
    done_mask = '0;
    for (int i = 0; i < NUM_PAT; i++) begin
      if (e_alive[i] && e_pos < pat_len(i)) begin
        if (lb != pat_char(i, e_pos)) begin
          alive_upd[i] = 1'b0;
        end else if (e_pos == pat_len(i) - POS_W'(1)) begin
          done_mask[i] = 1'b1;
        end
      end
    end
  end

  assign host = e_hmiss && alive_upd[PAT_HOST] && (e_pos >= POS_HOST)
                && (b != CHAR_CR) && (b != CHAR_LF);
  assign flush_cnt = (e_pos < POS_W'(HOLD_DEPTH)) ? HELD_CNT_W'(e_pos)
                                                  : HELD_CNT_W'(HOLD_DEPTH);

  // line state machine and job generation
  always_comb begin
    irl_nxt     = irl_r;
    pos_nxt     = pos_r;
    mode_nxt    = mode_r;
    alive_nxt   = alive_r;
    pidx_nxt    = pidx_r;
    pass_ok_nxt = pass_ok_r;
    len_nxt     = len_r;
    digits_nxt  = digits_r;
    ka_nxt      = ka_r;
    auth_nxt    = auth_r;
    hmiss_nxt   = hmiss_r;
    htaken_nxt  = htaken_r;
    held_nxt    = held_r;
    push        = 1'b0;
    push_cmd    = '{held: held_r, held_cnt: '0, cur_byte: b, host: 1'b0, done: 1'b0,
                    keep_alive: 1'b0, authorized: 1'b0, content_length: '0};

    if (accept) begin
      irl_nxt     = e_irl;
      pos_nxt     = e_pos;
      mode_nxt    = e_mode;
      alive_nxt   = e_alive;
      pidx_nxt    = e_pidx;
      pass_ok_nxt = e_pass_ok;
      len_nxt     = e_len;
      digits_nxt  = e_digits;
      ka_nxt      = e_ka;
      auth_nxt    = e_auth;
      hmiss_nxt   = e_hmiss;
      htaken_nxt  = e_htaken;

      if (e_irl) begin
        // request line passes through
        push = 1'b1;
        if (b == CHAR_LF) begin
          irl_nxt     = 1'b0;
          pos_nxt     = '0;
          mode_nxt    = MODE_DECIDE;
          alive_nxt   = '1;
          pass_ok_nxt = 1'b0;
          pidx_nxt    = '0;
          digits_nxt  = 1'b0;
          htaken_nxt  = 1'b0;
        end
      end else if (e_mode == MODE_END) begin
        // empty line: after its cr, only the lf goes out, carrying the head flags
        if (b == CHAR_LF) begin
          push                    = 1'b1;
          push_cmd.done           = 1'b1;
          push_cmd.keep_alive     = e_ka;
          push_cmd.authorized     = e_auth || !cfg.auth_enable;
          push_cmd.content_length = e_len;
          auth_nxt    = 1'b0;
          irl_nxt     = 1'b1;
          pos_nxt     = '0;
          mode_nxt    = MODE_DECIDE;
          alive_nxt   = '1;
          pass_ok_nxt = 1'b0;
          pidx_nxt    = '0;
          digits_nxt  = 1'b0;
          htaken_nxt  = 1'b0;
        end
      end else if (e_pos == '0 && b == CHAR_CR) begin
        mode_nxt = MODE_END;
        push     = 1'b1;
      end else begin
        // content length digits
        if (e_digits) begin
          if (is_digit) begin
            len_nxt = len_sat;
          end else begin
            digits_nxt = 1'b0;
          end
        end

        // password bytes after the basic prefix
        if (e_pass_ok && b != CHAR_LF) begin
          if (e_pidx < plen && b == pass_char) begin
            pidx_nxt = pidx_inc;
            if (pidx_inc >= plen) begin
              auth_nxt    = 1'b1;
              pass_ok_nxt = 1'b0;
            end
          end else begin
            pass_ok_nxt = 1'b0;
          end
        end

        alive_nxt = alive_upd;
        if (done_mask[PAT_PROXY_KA] || done_mask[PAT_CONN_KA]) begin
          ka_nxt = 1'b1;
        end
        if (done_mask[PAT_AUTH]) begin
          pidx_nxt = '0;
          if (cfg.pass_length == '0) begin
            auth_nxt    = 1'b1;
            pass_ok_nxt = 1'b0;
          end else begin
            pass_ok_nxt = 1'b1;
          end
        end
        if (done_mask[PAT_CLEN]) begin
          len_nxt    = '0;
          digits_nxt = 1'b1;
        end

        // forward or drop decision
        unique case (e_mode)
          MODE_DECIDE: begin
            if (!alive_upd[PAT_PROXY]) begin
              push              = 1'b1;
              push_cmd.held_cnt = flush_cnt;
              push_cmd.host     = host;
              mode_nxt          = MODE_FORWARD;
            end else if (done_mask[PAT_PROXY]) begin
              mode_nxt = MODE_DROP;
            end else if (e_pos < POS_W'(HOLD_DEPTH)) begin
              held_nxt[e_pos[HELD_CNT_W-1:0]] = b;
            end
          end
          MODE_FORWARD: begin
            push          = 1'b1;
            push_cmd.host = host;
          end
          MODE_DROP, MODE_END: begin
          end
          default: begin
          end
        endcase

        if (host && mode_nxt == MODE_FORWARD) begin
          htaken_nxt = 1'b1;
        end
        if (e_pos != POS_MAX) begin
          pos_nxt = e_pos + POS_W'(1);
        end

        if (b == CHAR_LF) begin
          if (htaken_nxt) begin
            hmiss_nxt = 1'b0;
          end
          pos_nxt     = '0;
          mode_nxt    = MODE_DECIDE;
          alive_nxt   = '1;
          pass_ok_nxt = 1'b0;
          pidx_nxt    = '0;
          digits_nxt  = 1'b0;
          htaken_nxt  = 1'b0;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irl_r     <= 1'b1;
      pos_r     <= '0;
      mode_r    <= MODE_DECIDE;
      alive_r   <= '1;
      pidx_r    <= '0;
      pass_ok_r <= 1'b0;
      len_r     <= '0;
      digits_r  <= 1'b0;
      ka_r      <= 1'b0;
      auth_r    <= 1'b0;
      hmiss_r   <= 1'b0;
      htaken_r  <= 1'b0;
    end else begin
      irl_r     <= irl_nxt;
      pos_r     <= pos_nxt;
      mode_r    <= mode_nxt;
      alive_r   <= alive_nxt;
      pidx_r    <= pidx_nxt;
      pass_ok_r <= pass_ok_nxt;
      len_r     <= len_nxt;
      digits_r  <= digits_nxt;
      ka_r      <= ka_nxt;
      auth_r    <= auth_nxt;
      hmiss_r   <= hmiss_nxt;
      htaken_r  <= htaken_nxt;
    end
  end

  // held line bytes
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

[design/phf_queue.sv]
module phf_queue import phf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output q_stat_t q_stat,
  output cmd_t    head
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_stat.full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.head_valid = (cnt_r != '0);
  assign head              = slot_r[rd_ptr_r];

  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && q_stat.head_valid;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[design/phf_back.sv]
module phf_back import phf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  q_stat_t    q_stat,
  input  cmd_t       head,
  output logic       pop,
  phf_out_if.source  out_chan
);

  logic [HELD_CNT_W-1:0] idx_r, idx_nxt;
  logic                  valid_r, valid_nxt;
  logic [7:0]            byte_r, byte_nxt;
  logic                  host_r, host_nxt;
  logic                  done_r, done_nxt;
  logic                  ka_r, ka_nxt;
  logic                  auth_r, auth_nxt;
  logic [31:0]           clen_r, clen_nxt;
  logic                  out_free;
  logic                  fire;
  logic                  last;

  assign out_free = !valid_r || out_chan.ready;
  assign fire     = out_free && q_stat.head_valid;
  assign last     = (idx_r == head.held_cnt);
  assign pop      = fire && last;

  // one result per cycle while the output is free: held bytes in order, then the current byte
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    host_nxt  = host_r;
    done_nxt  = done_r;
    ka_nxt    = ka_r;
    auth_nxt  = auth_r;
    clen_nxt  = clen_r;
    if (fire) begin
      valid_nxt = 1'b1;
      if (last) begin
        idx_nxt  = '0;
        byte_nxt = head.cur_byte;
        host_nxt = head.host;
        done_nxt = head.done;
        ka_nxt   = head.keep_alive;
        auth_nxt = head.authorized;
        clen_nxt = head.content_length;
      end else begin
        idx_nxt  = idx_r + HELD_CNT_W'(1);
        byte_nxt = head.held[idx_r];
        host_nxt = 1'b0;
        done_nxt = 1'b0;
        ka_nxt   = 1'b0;
        auth_nxt = 1'b0;
        clen_nxt = '0;
      end
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    host_r <= host_nxt;
    done_r <= done_nxt;
    ka_r   <= ka_nxt;
    auth_r <= auth_nxt;
    clen_r <= clen_nxt;
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.out_byte       = byte_r;
  assign out_chan.host_byte_flag = host_r;
  assign out_chan.head_done      = done_r;
  assign out_chan.keep_alive     = ka_r;
  assign out_chan.authorized     = auth_r;
  assign out_chan.content_length = clen_r;

endmodule

[design/proxy_header_filter.sv]
// path: the accepting edge writes a byte's job into the job queue; the output
//   register loads it from the queue head once the output is free
// throughput: one byte per cycle while the four-job queue is not full; a line
//   held and released adds up to five results, one per cycle when output is ready
// reset: synchronous, active low; clears line state, flags, config and pointers;
//   held bytes, queue slots and output payload keep contents; no clearing pass
module proxy_header_filter import phf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  phf_in_if.sink    in_chan,
  phf_out_if.source out_chan,
  phf_cfg_if.sink   cfg_chan
);

  cfg_t    cfg_r, cfg_nxt;
  q_stat_t q_stat;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  cmd_t    head;

  // configuration registers
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.reg_index)
        CFG_AUTH_ENABLE: cfg_nxt.auth_enable  = cfg_chan.wr_data[0];
        CFG_PASS_LENGTH: cfg_nxt.pass_length  = cfg_chan.wr_data[5:0];
        CFG_PASS_WORD0:  cfg_nxt.pass_word[0] = cfg_chan.wr_data;
        CFG_PASS_WORD1:  cfg_nxt.pass_word[1] = cfg_chan.wr_data;
        CFG_PASS_WORD2:  cfg_nxt.pass_word[2] = cfg_chan.wr_data;
        CFG_PASS_WORD3:  cfg_nxt.pass_word[3] = cfg_chan.wr_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // classify bytes and build forwarding jobs
  phf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg      (cfg_r),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // job queue between the two sides
  phf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_stat   (q_stat),
    .head     (head)
  );

  // serialise jobs into output items
  phf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  a_done_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.head_done |-> out_chan.out_byte == CHAR_LF)
    else $error("head end flagged on a byte other than lf");

  a_flags_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.head_done |->
      !out_chan.keep_alive && !out_chan.authorized && out_chan.content_length == '0)
    else $error("head flags set on an ordinary item");

  a_host_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.host_byte_flag |-> !out_chan.head_done)
    else $error("host mark on the final lf");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.head_valid)
    else $error("pop from an empty queue");

endmodule

[verif/tb_proxy_header_filter.sv]
`timescale 1ns / 100ps

module tb_proxy_header_filter;
  import phf_pkg::*;

  localparam int CYCLE_LIMIT            = 200000;
  localparam int PHASES                 = 6;
  localparam int RANDOM_BYTES_PER_PHASE = 10;
  localparam int DRAIN_CYCLES           = 10;

  typedef struct {
    logic [7:0] val;
    logic       first;
    logic       host_known;
  } head_byte_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        host;
    logic        done;
    logic        keep_alive;
    logic        authorized;
    logic [31:0] clen;
  } filter_out_t;

  logic clk = 1'b0;
  logic rst_n;

  phf_in_if  in_if ();
  phf_out_if out_if ();
  phf_cfg_if cfg_if ();

  proxy_header_filter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // header prefixes, lower case
  string prefix_txt [NUM_PAT];

  // password settings as last written
  logic        auth_on;
  logic [5:0]  pw_len;
  logic [63:0] pw_word [4];

  // predicted filter state
  logic               req_line;
  logic [POS_W-1:0]   line_pos;
  logic [7:0]         held_line [HOLD_DEPTH];
  line_mode_t         mode;
  logic [NUM_PAT-1:0] alive;
  logic [PIDX_W-1:0]  pw_index;
  logic               pw_matching;
  logic [31:0]        clen_acc;
  logic               clen_digits;
  logic               ka_seen;
  logic               auth_seen;
  logic               host_unknown;
  logic               host_marked;

  head_byte_t  pending_bytes [$];
  filter_out_t expected_out [$];
  int          queued;
  int          mismatches = 0;
  int          cycle_count = 0;

  head_byte_t  next_in;
  int          in_gap = 0;
  bit          in_calm = 1'b0;
  int          out_stall = 0;
  bit          out_calm = 1'b0;
  filter_out_t got;
  filter_out_t want;

  function automatic logic [7:0] pw_char(input int k);
    return pw_word[k / 8][(k % 8) * 8 +: 8];
  endfunction

  function automatic void emit_result(input logic [7:0] b, input logic host, input logic done);
    filter_out_t r;
    r.data       = b;
    r.host       = host;
    r.done       = done;
    r.keep_alive = done & ka_seen;
    r.authorized = done & (auth_seen | !auth_on);
    r.clen       = done ? clen_acc : 32'd0;
    expected_out.push_back(r);
  endfunction

  function automatic void start_line();
    line_pos    = '0;
    mode        = MODE_DECIDE;
    alive       = '1;
    pw_matching = 1'b0;
    pw_index    = '0;
    clen_digits = 1'b0;
    host_marked = 1'b0;
  endfunction

  // one accepted byte: update state and queue the bytes it releases
  function automatic void filter_byte(input logic [7:0] b, input logic first, input logic hk);
    logic [7:0]         lb;
    logic [NUM_PAT-1:0] hit;
    logic               host;
    logic [63:0]        acc;
    int                 p;
    int                 plen;
    if (first) begin
      req_line = 1'b1;
      start_line();
      clen_acc     = '0;
      ka_seen      = 1'b0;
      auth_seen    = 1'b0;
      host_unknown = !hk;
    end
    // request line passes through untouched
    if (req_line) begin
      emit_result(b, 1'b0, 1'b0);
      if (b == CHAR_LF) begin
        req_line = 1'b0;
        start_line();
      end
      return;
    end
    // blank line: after its cr, only the lf goes out, with the flags
    if (mode == MODE_END) begin
      if (b == CHAR_LF) begin
        emit_result(b, 1'b0, 1'b1);
        auth_seen = 1'b0;
        req_line  = 1'b1;
        start_line();
      end
      return;
    end
    if (line_pos == '0 && b == CHAR_CR) begin
      mode = MODE_END;
      emit_result(b, 1'b0, 1'b0);
      return;
    end
    p  = int'(line_pos);
    lb = (b >= CHAR_UC_A && b <= CHAR_UC_Z) ? b + CASE_DELTA : b;
    // decimal length, saturating
    if (clen_digits) begin
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
        acc      = 64'(clen_acc) * 64'd10 + 64'(b - CHAR_ZERO);
        clen_acc = (acc > 64'hFFFF_FFFF) ? '1 : acc[31:0];
      end else begin
        clen_digits = 1'b0;
      end
    end
    // password compare, original case
    if (pw_matching && b != CHAR_LF) begin
      plen = (pw_len > PASS_BYTES) ? PASS_BYTES : int'(pw_len);
      if (int'(pw_index) < plen && b == pw_char(int'(pw_index))) begin
        pw_index++;
        if (int'(pw_index) >= plen) begin
          auth_seen   = 1'b1;
          pw_matching = 1'b0;
        end
      end else begin
        pw_matching = 1'b0;
      end
    end
    // prefix matching
    hit = '0;
    for (int i = 0; i < NUM_PAT; i++) begin
      if (alive[i] && p < prefix_txt[i].len()) begin
        if (lb != prefix_txt[i][p])
          alive[i] = 1'b0;
        else if (p == prefix_txt[i].len() - 1)
          hit[i] = 1'b1;
      end
    end
    if (hit[PAT_PROXY_KA] || hit[PAT_CONN_KA])
      ka_seen = 1'b1;
    if (hit[PAT_AUTH]) begin
      pw_index = '0;
      if (pw_len == '0) begin
        auth_seen   = 1'b1;
        pw_matching = 1'b0;
      end else begin
        pw_matching = 1'b1;
      end
    end
    if (hit[PAT_CLEN]) begin
      clen_acc    = '0;
      clen_digits = 1'b1;
    end
    host = host_unknown && alive[PAT_HOST] && p >= prefix_txt[PAT_HOST].len() &&
           b != CHAR_CR && b != CHAR_LF;
    // forward, drop or hold
    if (mode == MODE_DECIDE) begin
      if (!alive[PAT_PROXY]) begin
        for (int k = 0; k < p && k < HOLD_DEPTH; k++)
          emit_result(held_line[k], 1'b0, 1'b0);
        emit_result(b, host, 1'b0);
        mode = MODE_FORWARD;
      end else if (hit[PAT_PROXY]) begin
        mode = MODE_DROP;
      end else if (p < HOLD_DEPTH) begin
        held_line[p] = b;
      end
    end else if (mode == MODE_FORWARD) begin
      emit_result(b, host, 1'b0);
    end
    if (host && mode == MODE_FORWARD)
      host_marked = 1'b1;
    if (line_pos < POS_MAX)
      line_pos++;
    if (b == CHAR_LF) begin
      if (host_marked)
        host_unknown = 1'b0;
      start_line();
    end
  endfunction

  // stimulus building
  function automatic void push_byte(input logic [7:0] v);
    head_byte_t h;
    h.val        = v;
    h.first      = 1'b0;
    h.host_known = 1'($urandom_range(0, 1));
    pending_bytes.push_back(h);
    queued++;
  endfunction

  function automatic void push_start(input logic [7:0] v, input logic hk);
    head_byte_t h;
    h.val        = v;
    h.first      = 1'b1;
    h.host_known = hk;
    pending_bytes.push_back(h);
    queued++;
  endfunction

  function automatic void push_str(input string s, input bit mix);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix && c >= "a" && c <= "z" && $urandom_range(0, 1))
        c = c - CASE_DELTA;
      push_byte(c);
    end
  endfunction

  function automatic void push_crlf();
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
  endfunction

  function automatic void push_line(input string s, input bit mix);
    push_str(s, mix);
    push_crlf();
  endfunction

  function automatic logic [7:0] any_printable();
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] any_but_lf();
    logic [7:0] c;
    do
      c = 8'($urandom_range(0, 255));
    while (c == CHAR_LF);
    return c;
  endfunction

  function automatic logic [63:0] printable_word();
    logic [63:0] w;
    for (int k = 0; k < 8; k++)
      w[k * 8 +: 8] = 8'($urandom_range(33, 126));
    return w;
  endfunction

  function automatic void queue_directed_heads();
    // request line extremes, host not known, empty password
    push_start(8'h00, 1'b0);
    push_byte(8'hFF);
    push_byte(CHAR_LF);
    push_line("HOST: ab", 1'b0);
    push_line("Proxy-Authorization: Basic ", 1'b0);
    push_line("Proxy-Connection: keep-alive", 1'b0);
    push_line("Content-Length: 4294967296", 1'b0);
    push_line("host: cd", 1'b0);
    push_byte(CHAR_CR);
    push_byte("z");
    push_byte(CHAR_LF);
    // host known, largest length, plain proxy line, near miss, bad sign
    push_start("G", 1'b1);
    push_byte(CHAR_LF);
    push_line("content-length: 4294967295", 1'b0);
    push_line("Proxy", 1'b0);
    push_line("proxz", 1'b0);
    push_line("Connection: Keep-Alive", 1'b0);
    push_line("content-length: -5", 1'b0);
    push_crlf();
    // restart while line bytes are held
    push_start("a", 1'b0);
    push_byte(CHAR_LF);
    push_str("prox", 1'b0);
    push_start("b", 1'b0);
    push_byte(CHAR_LF);
    push_line("Host: x", 1'b0);
    push_crlf();
  endfunction

  function automatic void gen_line();
    int         kind;
    int         n;
    int         sel;
    int         cut;
    int         plen;
    int         bad;
    logic [7:0] c;
    kind = $urandom_range(0, 11);
    case (kind)
      0: begin
        push_str(prefix_txt[PAT_PROXY_KA], 1'b1);
        if ($urandom_range(0, 1)) push_byte(any_printable());
        push_crlf();
      end
      1: begin
        // password right, with extra bytes, with one bad byte, or cut short
        plen = (pw_len > PASS_BYTES) ? PASS_BYTES : int'(pw_len);
        sel  = $urandom_range(0, 3);
        n    = (sel == 3 && plen > 0) ? $urandom_range(0, plen - 1) : plen;
        bad  = (plen > 0) ? $urandom_range(0, plen - 1) : 0;
        push_str(prefix_txt[PAT_AUTH], 1'b1);
        for (int k = 0; k < n; k++) begin
          c = pw_char(k);
          if (sel == 2 && k == bad)
            c = c ^ (8'h01 << $urandom_range(0, 7));
          push_byte(c);
        end
        if (sel == 1) push_byte(any_printable());
        push_crlf();
      end
      2: begin
        push_str(prefix_txt[PAT_PROXY], 1'b1);
        n = $urandom_range(0, 6);
        for (int k = 0; k < n; k++) push_byte(any_printable());
        push_crlf();
      end
      3: begin
        push_str(prefix_txt[PAT_HOST], 1'b1);
        n = $urandom_range(0, 8);
        for (int k = 0; k < n; k++) push_byte(any_printable());
        push_crlf();
      end
      4: push_line(prefix_txt[PAT_CONN_KA], 1'b1);
      5: push_line("connection: close", 1'b1);
      6: begin
        push_str(prefix_txt[PAT_CLEN], 1'b1);
        if ($urandom_range(0, 4) == 0) push_byte($urandom_range(0, 1) ? "-" : " ");
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 4);
        for (int k = 0; k < n; k++) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) begin
          push_byte("x");
          push_byte(CHAR_NINE);
        end
        push_crlf();
      end
      7: begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) push_byte(8'($urandom_range(97, 122)));
        push_str(": ", 1'b0);
        n = $urandom_range(0, 6);
        for (int k = 0; k < n; k++) push_byte(any_printable());
        push_crlf();
      end
      8: begin
        // prefix broken off part way
        sel = $urandom_range(0, NUM_PAT - 1);
        cut = $urandom_range(1, prefix_txt[sel].len() - 1);
        push_str(prefix_txt[sel].substr(0, cut - 1), 1'b1);
        push_byte(any_printable());
        push_crlf();
      end
      9: begin
        n = $urandom_range(0, 8);
        for (int k = 0; k < n; k++) push_byte(any_but_lf());
        push_byte(CHAR_LF);
      end
      10: begin
        n = $urandom_range(32, 40);
        for (int k = 0; k < n; k++) push_byte(any_printable());
        push_crlf();
      end
      default: push_byte(CHAR_LF);
    endcase
  endfunction

  function automatic void gen_head();
    int n;
    if ($urandom_range(0, 7) == 0)
      push_byte(any_printable());
    else
      push_start(any_printable(), 1'($urandom_range(0, 1)));
    n = $urandom_range(0, 5);
    for (int k = 0; k < n; k++) push_byte(any_but_lf());
    if ($urandom_range(0, 1)) push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    n = $urandom_range(0, 5);
    for (int k = 0; k < n; k++) gen_line();
    // abandoned head, the next start cuts it off
    if ($urandom_range(0, 9) == 0) begin
      push_str(prefix_txt[PAT_PROXY].substr(0, $urandom_range(0, 4)), 1'b1);
      return;
    end
    push_byte(CHAR_CR);
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) push_byte(any_but_lf());
    end
    push_byte(CHAR_LF);
  endfunction

  // register write, left asserted for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data   <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_AUTH_ENABLE: auth_on    = val[0];
      CFG_PASS_LENGTH: pw_len     = val[5:0];
      CFG_PASS_WORD0:  pw_word[0] = val;
      CFG_PASS_WORD1:  pw_word[1] = val;
      CFG_PASS_WORD2:  pw_word[2] = val;
      CFG_PASS_WORD3:  pw_word[3] = val;
      default: ;
    endcase
  endtask

  task automatic setup_password(input int ph);
    logic [63:0] w [4];
    logic        on;
    logic [5:0]  len;
    on = 1'b1;
    for (int k = 0; k < 4; k++) w[k] = printable_word();
    case (ph)
      0: len = 6'd0;
      1: len = 6'd32;
      2: begin
        on  = 1'b0;
        len = 6'd5;
        for (int k = 0; k < 4; k++) w[k] = '1;
      end
      3: begin
        len = 6'd1;
        for (int k = 0; k < 4; k++) w[k] = '0;
      end
      4: begin
        len = 6'($urandom_range(1, 32));
        for (int k = 0; k < 4; k++) w[k] = {$urandom, $urandom};
      end
      default: len = 6'($urandom_range(2, 8));
    endcase
    write_reg(CFG_AUTH_ENABLE, 64'(on));
    write_reg(CFG_PASS_LENGTH, 64'(len));
    write_reg(CFG_PASS_WORD0, w[0]);
    write_reg(CFG_PASS_WORD1, w[1]);
    write_reg(CFG_PASS_WORD2, w[2]);
    write_reg(CFG_PASS_WORD3, w[3]);
    cfg_if.valid <= 1'b0;
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready)
        filter_byte(in_if.in_byte, in_if.head_start, in_if.host_known);
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_in = pending_bytes.pop_front();
          in_if.in_byte    <= next_in.val;
          in_if.head_start <= next_in.first;
          in_if.host_known <= next_in.host_known;
          in_if.valid      <= 1'b1;
          if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
          in_gap = in_calm ? 0 : $urandom_range(0, 4);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.out_byte, out_if.host_byte_flag, out_if.head_done,
               out_if.keep_alive, out_if.authorized, out_if.content_length};
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected item, got byte %h host %b done %b", $time,
                   got.data, got.host, got.done);
          mismatches++;
        end else begin
          want = expected_out.pop_front();
          if (got !== want) begin
            $display("%0t: expected byte %h host %b done %b keep_alive %b authorized %b length %0d",
                     $time, want.data, want.host, want.done, want.keep_alive,
                     want.authorized, want.clen);
            $display("%0t:   actual byte %h host %b done %b keep_alive %b authorized %b length %0d",
                     $time, got.data, got.host, got.done, got.keep_alive,
                     got.authorized, got.clen);
            mismatches++;
          end
        end
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 4);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL proxy_header_filter");
      $finish;
    end
  end

  initial begin
    prefix_txt[PAT_PROXY_KA] = "proxy-connection: keep-alive";
    prefix_txt[PAT_AUTH]     = "proxy-authorization: basic ";
    prefix_txt[PAT_PROXY]    = "proxy";
    prefix_txt[PAT_HOST]     = "host: ";
    prefix_txt[PAT_CONN_KA]  = "connection: keep-alive";
    prefix_txt[PAT_CLEN]     = "content-length: ";

    in_if.valid      = 1'b0;
    in_if.in_byte    = '0;
    in_if.head_start = 1'b0;
    in_if.host_known = 1'b0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = '0;
    cfg_if.wr_data   = '0;
    rst_n            = 1'b0;

    // state after reset
    auth_on = 1'b0;
    pw_len  = '0;
    for (int k = 0; k < 4; k++) pw_word[k] = '0;
    for (int k = 0; k < HOLD_DEPTH; k++) held_line[k] = '0;
    req_line = 1'b1;
    start_line();
    clen_acc     = '0;
    ka_seen      = 1'b0;
    auth_seen    = 1'b0;
    host_unknown = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      setup_password(ph);
      if (ph == 0) queue_directed_heads();
      queued = 0;
      while (queued < RANDOM_BYTES_PER_PHASE) gen_head();
      // settle before the next register writes
      while (pending_bytes.size() != 0 || in_if.valid || expected_out.size() != 0)
        @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (mismatches == 0 && expected_out.size() == 0)
      $display("PASS proxy_header_filter");
    else
      $display("FAIL proxy_header_filter");
    $finish;
  end

endmodule

[filelist.f]
design/phf_pkg.sv
design/phf_in_if.sv
design/phf_out_if.sv
design/phf_cfg_if.sv
design/phf_front.sv
design/phf_queue.sv
design/phf_back.sv
design/proxy_header_filter.sv
verif/tb_proxy_header_filter.sv
